### hw/rtl/dbd_pkg.sv
`default_nettype none

package dbd_pkg;

  // Field widths of one transaction
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DIST_W  = 22;

  // Day number of any 14-bit year stays below 2**23
  localparam int DNUM_W  = 23;
  // Days before a month, at most 334 (+1 for a leap day)
  localparam int MDAYS_W = 9;

  localparam int DEFAULT_MAX_YEAR = 9999;

  // year / 100 as (year * 5243) >> 19, exact for every 14-bit year
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = YEAR_W + 13;
  localparam int CENT_W      = PROD_W - RECIP_SHIFT;

  localparam int DAYS_PER_YEAR = 365;
  localparam int YEARS_PER_CENT = 100;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  // Days in the months before the given month; month zero adds nothing,
  // months above twelve count as December.
  function automatic logic [MDAYS_W-1:0] month_start(input logic [MONTH_W-1:0] month);
    logic [MDAYS_W-1:0] days;
    case (month)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      default: days = 9'd334;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/days_between_dates_core.sv
`default_nettype none

// Channel    Ports                                          Handshake
// --------   --------------------------------------------   --------------------------
// command    first_day/month/year, second_day/month/year    start high, busy low
// result     day_distance                                   done high for one cycle
//
// Five register stages: input capture, reciprocal multiply for year / 100,
// year and month day counts, day number sum, absolute difference.
// One transaction enters every cycle while busy is low; done rises as its result
// leaves the absolute difference stage, with no gaps between back-to-back transactions.
// rst is synchronous and drops every transaction in flight; busy is high only
// during reset. The receiver cannot stall, so the pipeline never holds.
module days_between_dates_core #(
  parameter int MAX_YEAR = dbd_pkg::DEFAULT_MAX_YEAR
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [dbd_pkg::DAY_W-1:0]   first_day,
  input  wire logic [dbd_pkg::MONTH_W-1:0] first_month,
  input  wire logic [dbd_pkg::YEAR_W-1:0]  first_year,
  input  wire logic [dbd_pkg::DAY_W-1:0]   second_day,
  input  wire logic [dbd_pkg::MONTH_W-1:0] second_month,
  input  wire logic [dbd_pkg::YEAR_W-1:0]  second_year,
  output logic                             done,
  output logic [dbd_pkg::DIST_W-1:0]       day_distance
);

  import dbd_pkg::*;

  // Year compare runs wide enough to hold MAX_YEAR itself
  localparam int CMP_W = (YEAR_W > $clog2(MAX_YEAR + 1)) ? YEAR_W : $clog2(MAX_YEAR + 1);

  logic accept;

  // Stage valids
  logic va, vb, vc, vd;

  // Stage A: captured dates, year clamped
  date_t a_date [2];
  // Stage B: dates plus year * reciprocal
  date_t b_date [2];
  logic [PROD_W-1:0] b_prod [2];
  // Stage C: whole-year days, month days (with leap day), day
  logic [DNUM_W-1:0]  c_years [2];
  logic [MDAYS_W-1:0] c_months [2];
  logic [DAY_W-1:0]   c_day [2];
  // Stage D: day numbers
  logic [DNUM_W-1:0]  d_num [2];

  date_t in_date [2];
  date_t in_clamped [2];
  logic [DNUM_W-1:0]  c_years_next [2];
  logic [MDAYS_W-1:0] c_months_next [2];
  logic [DNUM_W-1:0]  d_num_next [2];
  logic [DNUM_W-1:0]  diff;
  logic [DIST_W-1:0]  day_distance_next;

  assign busy   = rst;
  assign accept = start && !busy;

  assign in_date[0] = '{day: first_day, month: first_month, year: first_year};
  assign in_date[1] = '{day: second_day, month: second_month, year: second_year};

  // Clamp years above the maximum
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      in_clamped[i] = in_date[i];
      if (CMP_W'(in_date[i].year) > CMP_W'(MAX_YEAR)) begin
        in_clamped[i].year = YEAR_W'(MAX_YEAR);
      end
    end
  end

  // Whole years, month offset and leap day
  always_comb begin
    logic [CENT_W-1:0] cent;
    logic [YEAR_W-1:0] cent_years;
    logic              on_cent;
    logic              leap;
    for (int i = 0; i < 2; i++) begin
      cent       = b_prod[i][PROD_W-1:RECIP_SHIFT];
      cent_years = YEAR_W'(cent * YEAR_W'(YEARS_PER_CENT));
      on_cent    = (cent_years == b_date[i].year);
      leap       = ((b_date[i].year[1:0] == 2'd0) && !on_cent) ||
                   (on_cent && (cent[1:0] == 2'd0));
      c_years_next[i] = DNUM_W'(b_date[i].year) * DNUM_W'(DAYS_PER_YEAR)
                      + DNUM_W'(b_date[i].year >> 2)
                      - DNUM_W'(cent)
                      + DNUM_W'(cent >> 2);
      c_months_next[i] = month_start(b_date[i].month)
                       + MDAYS_W'(leap && (b_date[i].month > 4'd2));
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      d_num_next[i] = c_years[i] + DNUM_W'(c_months[i]) + DNUM_W'(c_day[i]);
    end
  end

  // Absolute difference, saturated to the result width
  always_comb begin
    diff = (d_num[0] >= d_num[1]) ? (d_num[0] - d_num[1]) : (d_num[1] - d_num[0]);
    if (diff > DNUM_W'(DIST_MAX)) begin
      day_distance_next = DIST_MAX;
    end else begin
      day_distance_next = diff[DIST_W-1:0];
    end
  end

  // Advance the valid bits; reset drops everything in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      vc   <= 1'b0;
      vd   <= 1'b0;
      done <= 1'b0;
    end else begin
      va   <= accept;
      vb   <= va;
      vc   <= vb;
      vd   <= vc;
      done <= vd;
    end
  end

  // Payload stages follow their valids
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      a_date[i]   <= in_clamped[i];
      b_date[i]   <= a_date[i];
      b_prod[i]   <= PROD_W'(a_date[i].year) * PROD_W'(RECIP_100);
      c_years[i]  <= c_years_next[i];
      c_months[i] <= c_months_next[i];
      c_day[i]    <= b_date[i].day;
      d_num[i]    <= d_num_next[i];
    end
    day_distance <= day_distance_next;
  end

  // Every accepted transaction comes out with done
  assert property (@(posedge clk) disable iff (rst) accept |-> ##5 done)
    else $error("accepted transaction produced no result");

  // No result without an accepted transaction
  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept, 5))
    else $error("result without accepted transaction");

  // Identical dates give zero distance
  assert property (@(posedge clk) disable iff (rst)
    (accept && (first_day == second_day) && (first_month == second_month) &&
     (first_year == second_year)) |-> ##5 (day_distance == '0))
    else $error("equal dates gave nonzero distance");

endmodule

`default_nettype wire
